// ----- src/mctd_pkg.sv -----
// Shared types and constants for the multi-channel tick divider.
`default_nettype none

package mctd_pkg;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int FREQ_W   = 20;
   localparam int IDX_W    = 6;
   localparam int STAT_W   = 2;
   localparam int MASK_W   = 16;
   localparam int MINF_W   = 14;
   localparam int CNT_W    = 21;
   localparam int PER_W    = 20;
   localparam int CMP_W    = IDX_W + 1;

   // Base time and highest base tick rate
   localparam logic [FREQ_W-1:0] BASE_US       = 20'd1000000;
   localparam logic [FREQ_W-1:0] TOP_FREQUENCY = 20'd10000;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ATTACH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DETACH = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FREQ_ERR = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_CHAN = 2'd3;

   // Tick token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [PER_W-1:0]  interval;
   } cell_tok_type;

   // Table update broadcast to all cells
   typedef struct packed {
      logic              attach;
      logic              detach;
      logic [IDX_W-1:0]  index;
      logic [PER_W-1:0]  period;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- src/mctd_divider.sv -----
// Restoring divider: 1000000 / divisor, one quotient bit per cycle.
`default_nettype none

module mctd_divider
   import mctd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [FREQ_W-1:0]  divisor,
   output logic                    done,
   output logic [PER_W-1:0]        quotient
);

   localparam int STEP_W = $clog2(FREQ_W);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [STEP_W-1:0]   step_ff,  step_in;
   logic [FREQ_W:0]     rem_ff,   rem_in;
   logic [FREQ_W-1:0]   quo_ff,   quo_in;
   logic [FREQ_W-1:0]   div_ff,   div_in;
   logic [FREQ_W:0]     rem_shift;
   logic                fits;

   // One shift-compare-subtract step
   always_comb begin
      rem_shift = {rem_ff[FREQ_W-1:0], quo_ff[FREQ_W-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = BASE_US;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? (rem_shift - {1'b0, div_ff}) : rem_shift;
         quo_in  = {quo_ff[FREQ_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(FREQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- src/mctd_cell.sv -----
// One timer channel: countdown, reload period and enable; passes the tick token on.
`default_nettype none

module mctd_cell
   import mctd_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire cell_tok_type tok_in,
   output cell_tok_type      tok_out,
   output logic              fire
);

   logic signed [CNT_W-1:0]  cd_ff,   cd_in;
   logic [PER_W-1:0]         per_ff,  per_in;
   logic                     en_ff,   en_in;
   logic                     fire_ff, fire_in;
   logic                     tok_valid_ff;
   logic [PER_W-1:0]         tok_interval_ff;
   logic signed [CNT_W:0]    dec;
   logic signed [CNT_W:0]    reloaded;
   logic                     hit;

   assign hit = ctl.index == IDX_W'(INDEX);

   // Countdown update on token, table writes on broadcast
   always_comb begin
      dec      = {cd_ff[CNT_W-1], cd_ff} - $signed({2'b00, tok_in.interval});
      reloaded = dec + $signed({2'b00, per_ff});
      cd_in    = cd_ff;
      per_in   = per_ff;
      en_in    = en_ff;
      fire_in  = fire_ff;
      if (tok_in.valid) begin
         if (dec[CNT_W]) begin
            cd_in   = reloaded[CNT_W-1:0];
            fire_in = en_ff;
         end else begin
            cd_in   = dec[CNT_W-1:0];
            fire_in = 1'b0;
         end
      end
      if (ctl.attach && hit) begin
         per_in = ctl.period;
         cd_in  = $signed({1'b0, ctl.period});
         en_in  = 1'b1;
      end
      if (ctl.detach && hit) begin
         en_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff        <= 1'b0;
         fire_ff      <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         en_ff        <= en_in;
         fire_ff      <= fire_in;
         tok_valid_ff <= tok_in.valid;
      end
   end

   // Channel payload
   always_ff @(posedge clock) begin
      cd_ff           <= cd_in;
      per_ff          <= per_in;
      tok_interval_ff <= tok_in.interval;
   end

   assign tok_out.valid    = tok_valid_ff;
   assign tok_out.interval = tok_interval_ff;
   assign fire             = fire_ff;

endmodule

`default_nettype wire

// ----- src/multi_channel_tick_divider.sv -----
// Top level of the multi-channel tick divider.
//
// A row of CHANNELS timer cells divides one base tick. One item is handled at
// a time; a new item is taken while the previous result still waits on the rsp
// side. A tick walks a token down the cell row, one cell per cycle, and the
// result is formed once the token leaves the last cell. An attach runs a
// bit-serial divider for 1000000 / frequency; detach, failed attach and the
// unused command go straight to the response state.
`default_nettype none

module multi_channel_tick_divider
   import mctd_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // csr: min_base_hz[13:0]
   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   input  wire logic [15:0] csr_tdata,
   // req: command[1:0], frequency[21:2], channel_index[27:22]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,
   // rsp: status[1:0], fire_mask[17:2], assigned_index[23:18]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata
);

   localparam int NUM_W  = $clog2(CHANNELS + 1);
   localparam int MASK_N = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_TICK   = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [MINF_W-1:0]   minf_ff;
   logic [NUM_W-1:0]    count_ff, count_in;
   logic [PER_W-1:0]    interval_ff, interval_in;
   logic [MINF_W-1:0]   highest_ff, highest_in;
   logic                raise_ff, raise_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic [MASK_W-1:0]   res_mask_ff, res_mask_in;
   logic [IDX_W-1:0]    res_index_ff, res_index_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_data_ff, rsp_data_in;
   cell_ctl_type        ctl_ff, ctl_in;
   logic                head_tok_ff, head_tok_in;
   logic                div_start;
   logic                div_done;
   logic [PER_W-1:0]    div_quo;

   logic [CMD_W-1:0]    cmd;
   logic [FREQ_W-1:0]   freq;
   logic [IDX_W-1:0]    idx;
   logic                accept;
   logic                raise;
   logic                freq_err;
   logic                full;
   logic                bad_chan;
   logic [CMP_W-1:0]    count_ext;

   cell_tok_type        tok_bus [CHANNELS+1];
   logic [CHANNELS-1:0] fire_bits;
   logic [MASK_W-1:0]   fire_mask;

   // Request fields
   assign cmd    = req_tdata[1:0];
   assign freq   = req_tdata[21:2];
   assign idx    = req_tdata[27:22];
   assign accept = req_tvalid && req_tready;

   // Attach and detach checks
   assign count_ext = CMP_W'(count_ff);
   assign raise     = freq > FREQ_W'(highest_ff);
   assign freq_err  = (freq == '0) ||
                      (raise && ((freq < FREQ_W'(minf_ff)) || (freq > TOP_FREQUENCY)));
   assign full      = count_ff == NUM_W'(CHANNELS);
   assign bad_chan  = {1'b0, idx} >= count_ext;

   // Configuration register
   assign csr_tready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         minf_ff <= MINF_W'(1000);
      end else if (csr_tvalid && csr_tready) begin
         minf_ff <= csr_tdata[MINF_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      interval_in   = interval_ff;
      highest_in    = highest_ff;
      raise_in      = raise_ff;
      freq_in       = freq_ff;
      res_status_in = res_status_ff;
      res_mask_in   = res_mask_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ctl_in        = '0;
      ctl_in.index  = ctl_ff.index;
      ctl_in.period = ctl_ff.period;
      head_tok_in   = 1'b0;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_status_in = STAT_OK;
               res_mask_in   = '0;
               res_index_in  = '0;
               freq_in       = freq;
               raise_in      = raise;
               state_in      = ST_RESP;
               case (cmd)
                  CMD_TICK: begin
                     head_tok_in = 1'b1;
                     state_in    = ST_TICK;
                  end
                  CMD_ATTACH: begin
                     if (freq_err) begin
                        res_status_in = STAT_FREQ_ERR;
                     end else if (full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIVIDE;
                     end
                  end
                  CMD_DETACH: begin
                     if (bad_chan) begin
                        res_status_in = STAT_BAD_CHAN;
                     end else begin
                        ctl_in.detach = 1'b1;
                        ctl_in.index  = idx;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               ctl_in.attach = 1'b1;
               ctl_in.index  = IDX_W'(count_ff);
               ctl_in.period = div_quo;
               if (raise_ff) begin
                  interval_in = div_quo;
                  highest_in  = freq_ff[MINF_W-1:0];
               end
               res_index_in = IDX_W'(count_ff);
               count_in     = count_ff + 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_TICK: begin
            if (tok_bus[CHANNELS].valid) begin
               res_mask_in = fire_mask;
               state_in    = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_index_ff, res_mask_ff, res_status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         interval_ff  <= '0;
         highest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         ctl_ff       <= '0;
         head_tok_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         interval_ff  <= interval_in;
         highest_ff   <= highest_in;
         rsp_valid_ff <= rsp_valid_in;
         ctl_ff       <= ctl_in;
         head_tok_ff  <= head_tok_in;
      end
   end

   // Item payload
   always_ff @(posedge clock) begin
      raise_ff      <= raise_in;
      freq_ff       <= freq_in;
      res_status_ff <= res_status_in;
      res_mask_ff   <= res_mask_in;
      res_index_ff  <= res_index_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Period divider, loaded straight from the accepted beat
   mctd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (freq),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Row of channel cells
   assign tok_bus[0].valid    = head_tok_ff;
   assign tok_bus[0].interval = interval_ff;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
      mctd_cell #(
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl_ff),
         .tok_in  (tok_bus[i]),
         .tok_out (tok_bus[i+1]),
         .fire    (fire_bits[i])
      );
   end

   // Fire bits of the low channels
   always_comb begin
      fire_mask = '0;
      for (int i = 0; i < MASK_N; i++) begin
         fire_mask[i] = fire_bits[i];
      end
   end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the multi-channel tick divider: directed and random beats.
`timescale 1ns / 1ps

module tb;
   import mctd_pkg::*;

   localparam int NCHAN     = 16;
   localparam int LIMIT     = 400000;
   localparam int TAIL_WAIT = 40;

   // Command code the block leaves unused
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Request beat, command in the low bits as on req_tdata
   typedef struct packed {
      logic [IDX_W-1:0]  chan;
      logic [FREQ_W-1:0] freq;
      logic [CMD_W-1:0]  cmd;
   } timer_req_type;

   // Result beat, status in the low bits as on rsp_tdata
   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [MASK_W-1:0] mask;
      logic [STAT_W-1:0] status;
   } timer_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [15:0] csr_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   // Shadow of the channel table
   logic [MINF_W-1:0]       lowest_rate = 14'd1000;
   logic [MINF_W-1:0]       top_rate = '0;
   logic [PER_W-1:0]        tick_us = '0;
   int                      num_channels = 0;
   logic signed [CNT_W-1:0] countdown [NCHAN];
   logic [PER_W-1:0]        period_us [NCHAN];
   logic [NCHAN-1:0]        chan_enabled = '0;

   timer_req_type pending_req [$];
   timer_rsp_type due_results [$];

   int   mismatches = 0;
   int   cycle_count = 0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   logic req_took = 1'b0;
   logic calm = 1'b0;

   multi_channel_tick_divider #(
      .CHANNELS (NCHAN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one request to the shadow table and return the result it must give
   function automatic timer_rsp_type tick_table_step(timer_req_type item);
      timer_rsp_type res;
      int            c;
      bit            raise;
      res = '0;
      case (item.cmd)
         CMD_TICK: begin
            for (int i = 0; i < num_channels; i++) begin
               c = int'(countdown[i]) - int'(tick_us);
               if (c < 0) begin
                  c += int'(period_us[i]);
                  if (chan_enabled[i] && i < MASK_W) res.mask[i] = 1'b1;
               end
               countdown[i] = c[CNT_W-1:0];
            end
         end
         CMD_ATTACH: begin
            raise = item.freq > top_rate;
            if (item.freq == 0 ||
                (raise && (item.freq < lowest_rate || item.freq > TOP_FREQUENCY))) begin
               res.status = STAT_FREQ_ERR;
            end else if (num_channels >= NCHAN) begin
               res.status = STAT_FULL;
            end else begin
               if (raise) begin
                  tick_us  = BASE_US / item.freq;
                  top_rate = item.freq[MINF_W-1:0];
               end
               period_us[num_channels]    = BASE_US / item.freq;
               countdown[num_channels]    = {1'b0, period_us[num_channels]};
               chan_enabled[num_channels] = 1'b1;
               res.index    = num_channels[IDX_W-1:0];
               num_channels = num_channels + 1;
            end
         end
         CMD_DETACH: begin
            if (item.chan >= num_channels) res.status = STAT_BAD_CHAN;
            else chan_enabled[item.chan] = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic add_req(input logic [CMD_W-1:0] cmd, input int freq, input int chan);
      timer_req_type item;
      item.cmd  = cmd;
      item.freq = freq[FREQ_W-1:0];
      item.chan = chan[IDX_W-1:0];
      pending_req = {pending_req, item};
   endtask

   // Mostly ticks; attaches aimed around the current base rate
   task automatic add_random_reqs(input int count);
      int r;
      int k;
      int freq;
      int chan;
      for (int n = 0; n < count; n++) begin
         r    = $urandom_range(0, 99);
         freq = $urandom_range(0, 1000000);
         chan = $urandom_range(0, 63);
         if (r < 80) begin
            add_req(CMD_TICK, freq, chan);
         end else if (r < 86) begin
            k = $urandom_range(0, 9);
            if (k < 5)
               freq = (top_rate == 0) ? $urandom_range(1000, 4000)
                                      : top_rate / $urandom_range(1, 6);
            else if (k < 7)
               freq = $urandom_range(top_rate + 1, top_rate + top_rate / 4 + 50);
            else if (k == 7)
               freq = 0;
            else if (k == 8)
               freq = $urandom_range(1, 20000);
            add_req(CMD_ATTACH, freq, chan);
         end else if (r < 98) begin
            if ($urandom_range(0, 3) != 0) chan = $urandom_range(0, NCHAN + 1);
            add_req(CMD_DETACH, freq, chan);
         end else begin
            add_req(CMD_UNUSED, freq, chan);
         end
      end
   endtask

   // Hold the sender until every result is back
   task automatic wait_idle();
      while (pending_req.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_min_rate(input int rate);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {2'b00, rate[MINF_W-1:0]};
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // Stimulus sequence
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Empty table, error cases, then a few channels at mixed rates
      add_req(CMD_TICK, 0, 0);
      add_req(CMD_DETACH, 0, 0);
      add_req(CMD_UNUSED, 1000000, 63);
      add_req(CMD_ATTACH, 0, 0);
      add_req(CMD_ATTACH, 500, 0);
      add_req(CMD_ATTACH, 10001, 0);
      add_req(CMD_ATTACH, 1000000, 0);
      add_req(CMD_ATTACH, 1000, 0);
      add_req(CMD_ATTACH, 999, 0);
      add_req(CMD_ATTACH, 2000, 0);
      add_req(CMD_ATTACH, 1, 0);
      repeat (4) add_req(CMD_TICK, 1048575, 63);
      add_req(CMD_DETACH, 0, 1);
      add_req(CMD_DETACH, 0, 1);
      add_req(CMD_DETACH, 1048575, 63);
      add_req(CMD_DETACH, 0, 4);
      repeat (2) add_req(CMD_TICK, 0, 0);
      wait_idle();

      write_min_rate(1);
      add_random_reqs(220);
      wait_idle();

      write_min_rate($urandom_range(1, 10000));
      add_random_reqs(220);
      wait_idle();

      // Top of the range: only 10000 Hz can raise the rate now
      write_min_rate(10000);
      add_req(CMD_ATTACH, 9999, 0);
      add_req(CMD_ATTACH, 10000, 0);
      add_random_reqs(200);
      wait_idle();

      write_min_rate(1000);
      calm <= 1'b1;
      add_random_reqs(240);
      wait_idle();

      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (req_gap != 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_req.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            req_gap    <= $urandom_range(0, 17);
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0000, pending_req.pop_front()};
         end
      end
   end

   // Result back-pressure
   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && !reset && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      timer_rsp_type want;
      timer_rsp_type got;
      timer_rsp_type pred;
      req_took <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (csr_tvalid && csr_tready) lowest_rate = csr_tdata[MINF_W-1:0];
         if (req_tvalid && req_tready) begin
            pred        = tick_table_step(timer_req_type'(req_tdata[27:0]));
            due_results = {due_results, pred};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = timer_rsp_type'(rsp_tdata);
            if (due_results.size() == 0) begin
               $error("unexpected rsp beat %h", rsp_tdata);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.mask !== want.mask) begin
                  $error("fire_mask: expected %h, got %h", want.mask, got.mask);
                  mismatches++;
               end
               if (got.index !== want.index) begin
                  $error("assigned_index: expected %0d, got %0d", want.index, got.index);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
src/mctd_pkg.sv
src/mctd_divider.sv
src/mctd_cell.sv
src/multi_channel_tick_divider.sv
verif/tb.sv
